FILE: hdl/cps_pkg.sv
// ----------------------------------------------------------------------------
// Cycle profile statistics package
// Shared widths, types, register codes and state encoding for the profiler.
// ----------------------------------------------------------------------------
package cps_pkg;

  // Field and register widths.
  localparam int COUNT_W       = 32;  // counter readings and elapsed counts
  localparam int TOTAL_W       = 64;  // running total and sample count
  localparam int OVH_W         = 16;
  localparam int FREQ_W        = 20;
  localparam int HZ_W          = 32;
  localparam int LOAD_W        = 10;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 2;

  // Load arithmetic: cycles * (run_freq_hz * 100) / cpu_hz.
  localparam int PCT_SCALE     = 100;
  localparam int FSCALED_W     = FREQ_W + 7;            // run_freq_hz * 100
  localparam int PROD_W        = COUNT_W + FSCALED_W;   // full product width
  localparam int DIV_W         = TOTAL_W;               // shared divider width

  localparam int COUNTER_WIDTH_DEF = 32;

  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [TOTAL_W-1:0]   total_t;
  typedef logic [OVH_W-1:0]     ovh_t;
  typedef logic [FREQ_W-1:0]    freq_t;
  typedef logic [HZ_W-1:0]      hz_t;
  typedef logic [LOAD_W-1:0]    load_t;
  typedef logic [FSCALED_W-1:0] fscaled_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [DIV_W-1:0]     div_t;

  localparam load_t  LOAD_MAX       = load_t'(1023);
  localparam ovh_t   OVH_RESET      = ovh_t'(0);
  localparam freq_t  FREQ_RESET     = freq_t'(1000);
  localparam hz_t    CPU_HZ_RESET   = hz_t'(800000000);

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERHEAD = 2'd0,
    CFG_RUN_FREQ = 2'd1,
    CFG_CPU_HZ   = 2'd2
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_TRIM,
    ST_ACC,
    ST_L_AVG,
    ST_W_AVG,
    ST_L_NOW,
    ST_W_NOW,
    ST_L_LAVG,
    ST_W_LAVG,
    ST_DONE
  } state_t;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: hdl/cps_mul_serial.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-add multiplier taking one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cps_mul_serial (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cps_pkg::fscaled_t   mcand,
  input  cps_pkg::count_t     mplier,
  output cps_pkg::prod_t      product,
  output cps_pkg::unit_stat_t stat
);

  localparam int MC_W   = cps_pkg::FSCALED_W;
  localparam int MP_W   = cps_pkg::COUNT_W;
  localparam int STEP_W = $clog2(MP_W);

  cps_pkg::prod_t    acc;
  cps_pkg::fscaled_t mcand_r;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [MC_W:0]     sum;
  cps_pkg::prod_t    acc_next;

  // The low half starts as the multiplier and drains out to the right while
  // partial sums build up in the high half.
  always_comb begin
    sum      = {1'b0, acc[cps_pkg::PROD_W-1:MP_W]} + (acc[0] ? {1'b0, mcand_r} : '0);
    acc_next = {sum, acc[MP_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(MP_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc     <= {{MC_W{1'b0}}, mplier};
      mcand_r <= mcand;
    end else if (busy) begin
      acc <= acc_next;
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hdl/cps_div_serial.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cps_div_serial (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cps_pkg::div_t       numer,
  input  cps_pkg::div_t       denom,
  output cps_pkg::div_t       quot,
  output cps_pkg::unit_stat_t stat
);

  localparam int W      = cps_pkg::DIV_W;
  localparam int STEP_W = $clog2(W);

  cps_pkg::div_t     rem;
  cps_pkg::div_t     shreg;
  cps_pkg::div_t     dvs;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [W:0]        trial;
  logic [W:0]        diff;
  logic              fits;

  // The numerator shifts out at the top while quotient bits shift in at the
  // bottom, so the same register ends up holding the quotient. A zero
  // divisor yields an all-ones quotient.
  always_comb begin
    trial = {rem, shreg[W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= numer;
      dvs   <= denom;
    end else if (busy) begin
      rem   <= fits ? diff[W-1:0] : trial[W-1:0];
      shreg <= {shreg[W-2:0], fits};
    end
  end

  assign quot      = shreg;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hdl/cycle_profile_statistics.sv
// ----------------------------------------------------------------------------
// Cycle profile statistics
// Running maximum, average and CPU load of a profiled loop from counter pairs.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   -------  ---------  -------------------  -----------------------------------
//   in       sink       in_valid / in_stall   kind, start_count, end_count
//   out      source     out_valid / out_stall elapsed_cycles, max_cycles,
//                                             avg_cycles, load_now_pct,
//                                             load_avg_pct, sample_count
//   cfg      sink       cfg_write             cfg_index, cfg_data
//
// A sample transaction passes the difference, trim and accumulation states
// and three passes of the shared 64-bit serial divider (average, current
// load, average load), which set its time, then is loaded into the output
// register, and no new input is taken before that load. The 32-step serial
// multiplier overlaps with the divider. A clear transaction goes straight
// from idle to the done state, where it is loaded. Reset is synchronous and
// restores the register defaults and zero statistics. The result sits in an
// output register, so a new input transaction is taken while the previous
// result is still stalled; only the final hand-over waits for the register.
//
module cycle_profile_statistics #(
  parameter int COUNTER_WIDTH = cps_pkg::COUNTER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [cps_pkg::COUNT_W-1:0]       start_count,
  input  logic [cps_pkg::COUNT_W-1:0]       end_count,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cps_pkg::COUNT_W-1:0]       elapsed_cycles,
  output logic [cps_pkg::COUNT_W-1:0]       max_cycles,
  output logic [cps_pkg::COUNT_W-1:0]       avg_cycles,
  output logic [cps_pkg::LOAD_W-1:0]        load_now_pct,
  output logic [cps_pkg::LOAD_W-1:0]        load_avg_pct,
  output logic [cps_pkg::TOTAL_W-1:0]       sample_count,

  input  logic                              cfg_write,
  input  logic [cps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Counter readings are masked to the width of the counter that produced
  // them; counters wider than the input fields see no masking.
  localparam int CNT_W = (COUNTER_WIDTH < cps_pkg::COUNT_W) ? COUNTER_WIDTH
                                                            : cps_pkg::COUNT_W;
  localparam cps_pkg::count_t COUNT_MASK =
    cps_pkg::count_t'((65'h1 << CNT_W) - 65'h1);

  // Configuration registers.
  cps_pkg::ovh_t  overhead;
  cps_pkg::freq_t run_freq;
  cps_pkg::hz_t   cpu_hz;

  // Statistics kept across samples.
  cps_pkg::count_t peak_cycles;
  cps_pkg::total_t cycle_total;
  cps_pkg::total_t samples_seen;

  // Per-transaction working registers.
  cps_pkg::count_t start_r;
  cps_pkg::count_t end_r;
  cps_pkg::count_t diff_r;
  cps_pkg::count_t elapsed_r;
  cps_pkg::count_t avg_r;
  cps_pkg::load_t  load_now_r;
  cps_pkg::load_t  load_avg_r;

  cps_pkg::state_t state;
  cps_pkg::state_t state_next;

  // Sequencer controls.
  logic take;
  logic clear_all;
  logic launch_avg;
  logic launch_now;
  logic launch_lavg;
  logic cap_avg;
  logic cap_now;
  logic cap_lavg;
  logic out_load;
  logic units_free;

  // Arithmetic units and their operands.
  cps_pkg::fscaled_t   freq_scaled;
  cps_pkg::count_t     mul_mplier;
  cps_pkg::prod_t      mul_product;
  cps_pkg::unit_stat_t mul_stat;
  logic                mul_start;
  cps_pkg::div_t       div_numer;
  cps_pkg::div_t       div_denom;
  cps_pkg::div_t       div_quot;
  cps_pkg::unit_stat_t div_stat;
  logic                div_start;
  cps_pkg::count_t     avg_sat;
  cps_pkg::load_t      load_sat;

  // ---------------------------------------------------------------------------
  // Configuration port. The user must make writes land only while the block
  // is idle; the block does not enforce it and uses the registers directly.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      overhead <= cps_pkg::OVH_RESET;
      run_freq <= cps_pkg::FREQ_RESET;
      cpu_hz   <= cps_pkg::CPU_HZ_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cps_pkg::CFG_OVERHEAD: overhead <= cfg_data[cps_pkg::OVH_W-1:0];
        cps_pkg::CFG_RUN_FREQ: run_freq <= cfg_data[cps_pkg::FREQ_W-1:0];
        cps_pkg::CFG_CPU_HZ:   cpu_hz   <= cfg_data[cps_pkg::HZ_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer. A sample walks through difference, overhead trim and
  // accumulation, then three divider passes: total / count, current cycles
  // times scaled frequency over cpu_hz, and the same for the average. The
  // multiplier for each load runs alongside the preceding division.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign units_free = !div_stat.busy && !mul_stat.busy;

  always_comb begin
    state_next = state;
    unique case (state)
      cps_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (kind == cps_pkg::KIND_CLEAR) ? cps_pkg::ST_DONE
                                                     : cps_pkg::ST_DIFF;
        end
      end
      cps_pkg::ST_DIFF:   state_next = cps_pkg::ST_TRIM;
      cps_pkg::ST_TRIM:   state_next = cps_pkg::ST_ACC;
      cps_pkg::ST_ACC:    state_next = cps_pkg::ST_L_AVG;
      cps_pkg::ST_L_AVG: begin
        if (units_free) state_next = cps_pkg::ST_W_AVG;
      end
      cps_pkg::ST_W_AVG: begin
        if (div_stat.done) state_next = cps_pkg::ST_L_NOW;
      end
      cps_pkg::ST_L_NOW: begin
        if (units_free) state_next = cps_pkg::ST_W_NOW;
      end
      cps_pkg::ST_W_NOW: begin
        if (div_stat.done) state_next = cps_pkg::ST_L_LAVG;
      end
      cps_pkg::ST_L_LAVG: begin
        if (units_free) state_next = cps_pkg::ST_W_LAVG;
      end
      cps_pkg::ST_W_LAVG: begin
        if (div_stat.done) state_next = cps_pkg::ST_DONE;
      end
      cps_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = cps_pkg::ST_IDLE;
      end
      default: state_next = cps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != cps_pkg::ST_IDLE);
    take        = (state == cps_pkg::ST_IDLE) && in_valid;
    clear_all   = take && (kind == cps_pkg::KIND_CLEAR);
    launch_avg  = (state == cps_pkg::ST_L_AVG)  && units_free;
    launch_now  = (state == cps_pkg::ST_L_NOW)  && units_free;
    launch_lavg = (state == cps_pkg::ST_L_LAVG) && units_free;
    cap_avg     = (state == cps_pkg::ST_W_AVG)  && div_stat.done;
    cap_now     = (state == cps_pkg::ST_W_NOW)  && div_stat.done;
    cap_lavg    = (state == cps_pkg::ST_W_LAVG) && div_stat.done;
    out_load    = (state == cps_pkg::ST_DONE)   && (!out_valid || !out_stall);
  end

  // ---------------------------------------------------------------------------
  // Arithmetic units. The multiplicand is run_freq_hz * 100. The first
  // multiplication (elapsed cycles) starts with the average division; the
  // second (average cycles) starts with the current-load division, which
  // latches the earlier product on the same edge.
  // ---------------------------------------------------------------------------
  assign freq_scaled = cps_pkg::fscaled_t'(run_freq) *
                       cps_pkg::fscaled_t'(cps_pkg::PCT_SCALE);

  assign mul_start  = launch_avg || launch_now;
  assign mul_mplier = launch_avg ? elapsed_r : avg_r;

  assign div_start  = launch_avg || launch_now || launch_lavg;
  assign div_numer  = launch_avg ? cycle_total : cps_pkg::div_t'(mul_product);
  assign div_denom  = launch_avg ? samples_seen : cps_pkg::div_t'(cpu_hz);

  cps_mul_serial u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (freq_scaled),
    .mplier  (mul_mplier),
    .product (mul_product),
    .stat    (mul_stat)
  );

  cps_div_serial u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // Saturation of the divider result. A zero cpu_hz gives an all-ones
  // quotient, which saturates the load to its maximum as required.
  assign avg_sat  = (div_quot[cps_pkg::DIV_W-1:cps_pkg::COUNT_W] != '0)
                    ? '1 : div_quot[cps_pkg::COUNT_W-1:0];
  assign load_sat = (div_quot[cps_pkg::DIV_W-1:cps_pkg::LOAD_W] != '0)
                    ? cps_pkg::LOAD_MAX : div_quot[cps_pkg::LOAD_W-1:0];

  // ---------------------------------------------------------------------------
  // Statistics. A clear transaction zeroes all statistics, including the result
  // fields that feed the output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_cycles  <= '0;
      cycle_total  <= '0;
      samples_seen <= '0;
    end else if (clear_all) begin
      peak_cycles  <= '0;
      cycle_total  <= '0;
      samples_seen <= '0;
    end else if (state == cps_pkg::ST_ACC) begin
      if (elapsed_r > peak_cycles) peak_cycles <= elapsed_r;
      cycle_total  <= cycle_total + cps_pkg::total_t'(elapsed_r);
      samples_seen <= samples_seen + cps_pkg::total_t'(1);
    end
  end

  // Working registers. The elapsed count is the absolute difference of the
  // masked readings; the overhead is removed only when it fits.
  always_ff @(posedge clk) begin
    if (take) begin
      start_r <= start_count & COUNT_MASK;
      end_r   <= end_count & COUNT_MASK;
    end
    if (state == cps_pkg::ST_DIFF) begin
      diff_r <= (end_r >= start_r) ? (end_r - start_r) : (start_r - end_r);
    end
    if (clear_all) begin
      elapsed_r  <= '0;
      avg_r      <= '0;
      load_now_r <= '0;
      load_avg_r <= '0;
    end else begin
      if (state == cps_pkg::ST_TRIM) begin
        elapsed_r <= (diff_r >= cps_pkg::count_t'(overhead))
                     ? (diff_r - cps_pkg::count_t'(overhead)) : diff_r;
      end
      // A sample count that has wrapped to zero reports a zero average.
      if (cap_avg) avg_r <= (samples_seen == '0) ? '0 : avg_sat;
      if (cap_now) load_now_r <= load_sat;
      if (cap_lavg) load_avg_r <= load_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. It is reloaded only when empty or being taken, so a
  // stalled result never changes.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      elapsed_cycles <= elapsed_r;
      max_cycles     <= peak_cycles;
      avg_cycles     <= avg_r;
      load_now_pct   <= load_now_r;
      load_avg_pct   <= load_avg_r;
      sample_count   <= samples_seen;
    end
  end

endmodule
